[rtl/lslb_pkg.sv]
// ----------------------------------------------------------------------------
// lslb_pkg: shared types and constants for the LED strip length detector
// Field widths, request kinds, result commands, detection phases and the
// divide-by-three helper used for the pixel count.
// ----------------------------------------------------------------------------
package lslb_pkg;

	// field widths
	localparam int unsigned CH_W     = 5;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned POS_W    = 11;
	localparam int unsigned COUNT_W  = 10;

	// request kinds
	localparam logic KIND_START  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// result commands
	localparam logic CMD_PROBE  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// pixel types
	localparam logic PIX_GRB  = 1'b0;
	localparam logic PIX_RGBW = 1'b1;

	// probe lengths in bytes
	localparam logic [1:0] COARSE_LEN = 2'd3;
	localparam logic [1:0] FINE_LEN   = 2'd1;

	// coarse bisection runs while the halved step is at least this
	localparam logic [POS_W-1:0] MIN_COARSE_STEP = 11'd6;

	// detection phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_FIRST  = 4'b0010,
		PH_COARSE = 4'b0100,
		PH_FINE   = 4'b1000
	} phase_t;

	// floor(x / 3) for a 12-bit x (below 4096), kept to the count width
	function automatic logic [COUNT_W-1:0] div3(input logic [11:0] x);
		logic [23:0] p;
		p = {12'd0, x} * 24'd2731;
		return p[22:13];
	endfunction

endpackage

[rtl/lslb_ifs.sv]
// ----------------------------------------------------------------------------
// lslb_ifs: request and result channels of the LED strip length detector
// Valid/ready channels; a request is taken when valid and ready are both high.
// ----------------------------------------------------------------------------

// incoming request: start or sample reply
interface lslb_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [lslb_pkg::CH_W-1:0]     channel;
	logic [lslb_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, kind, channel, sample, input ready);
	modport sink   (input valid, kind, channel, sample, output ready);
endinterface

// outgoing result: probe command or finish report
interface lslb_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [lslb_pkg::CH_W-1:0]    out_channel;
	logic [lslb_pkg::POS_W-1:0]   range_start;
	logic [lslb_pkg::POS_W-1:0]   range_end;
	logic                         fine_precision;
	logic                         pixel_format;
	logic [lslb_pkg::COUNT_W-1:0] pixel_total;
	logic                         uneven_count;

	modport source (output valid, command, out_channel, range_start, range_end,
		fine_precision, pixel_format, pixel_total, uneven_count, input ready);
	modport sink   (input valid, command, out_channel, range_start, range_end,
		fine_precision, pixel_format, pixel_total, uneven_count, output ready);
endinterface

[rtl/led_strip_length_bisection_core.sv]
// ----------------------------------------------------------------------------
// led_strip_length_bisection_core: LED strip length and pixel width detector
// Bisects on current samples: coarse 3-byte probes, then fine 1-byte probes,
// then reports pixel type and count for the probed channel.
// ----------------------------------------------------------------------------
//
// channel   | dir | handshake        | payload
// ----------+-----+------------------+---------------------------------------
// req       | in  | valid / ready    | kind, channel, sample
// rsp       | out | valid / ready    | command, out_channel, range, counts
// cfg       | in  | cfg_we           | cfg_wdata (off_reference)
//
// One request per cycle is taken while req.ready is high; its result (if any)
// is registered and shows on rsp in the cycle after acceptance.
// req.ready is high while the result register is empty or being drained,
// so a stalled rsp holds at most one result and back-pressures req.
// arst_n clears the phase, bounds, reference and result valid at once.
//
module led_strip_length_bisection_core #(
	parameter int unsigned MAX_STRIP_BYTES = 1536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lslb_pkg::SAMPLE_W-1:0] cfg_wdata,
	lslb_req_if.sink                      req,
	lslb_rsp_if.source                    rsp
);

	localparam int unsigned PW = lslb_pkg::POS_W;
	localparam int unsigned CW = lslb_pkg::COUNT_W;
	localparam logic [PW-1:0] INIT_FIRST_OFF = PW'(MAX_STRIP_BYTES);
	localparam logic [PW-1:0] INIT_PROBE     = PW'(MAX_STRIP_BYTES >> 1);
	localparam logic [PW-1:0] INIT_STEP      = PW'(MAX_STRIP_BYTES >> 2);

	// state
	lslb_pkg::phase_t              phase_q, phase_n;
	logic [PW-1:0]                 last_on_q, last_on_n;
	logic [PW-1:0]                 first_off_q, first_off_n;
	logic [PW-1:0]                 probe_q, probe_n;
	logic [PW-1:0]                 step_q, step_n;
	logic [PW-1:0]                 coarse_base_q, coarse_base_n;
	logic [lslb_pkg::CH_W-1:0]     chan_q, chan_n;
	logic [lslb_pkg::SAMPLE_W-1:0] off_ref_q;

	// result register
	logic                          rsp_valid_q;
	logic                          cmd_q, fine_q, ptype_q, uneven_q;
	logic [lslb_pkg::CH_W-1:0]     ochan_q;
	logic [PW-1:0]                 rstart_q, rend_q;
	logic [CW-1:0]                 count_q;

	// next result
	logic                          has_rsp;
	logic                          cmd_n, fine_n, ptype_n, uneven_n;
	logic [PW-1:0]                 rstart_n;
	logic [1:0]                    rlen_n;
	logic [CW-1:0]                 count_n;

	logic                          accept;
	logic [12:0]                   th12;
	logic [14:0]                   th14;
	logic                          off12, off14;

	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;

	// off thresholds from the dark reference
	assign th12  = 13'(({1'b0, off_ref_q} + 17'd8) >> 4) + 13'd2;
	assign th14  = 15'(({1'b0, off_ref_q} + 17'd2) >> 2) + 15'd3;
	assign off12 = req.sample <= {3'd0, th12};
	assign off14 = req.sample <= {1'b0, th14};

	// next state and result for the request at the port
	always_comb begin
		logic [PW-1:0] c_step;
		logic [PW-1:0] c_last;
		logic [PW-1:0] c_first;
		logic [PW-1:0] c_pos;
		logic [PW-1:0] f_low;
		logic [PW:0]   sum;
		logic [15:0]   diff;
		logic [11:0]   fo;

		phase_n       = phase_q;
		last_on_n     = last_on_q;
		first_off_n   = first_off_q;
		probe_n       = probe_q;
		step_n        = step_q;
		coarse_base_n = coarse_base_q;
		chan_n        = chan_q;
		has_rsp       = 1'b0;
		cmd_n         = lslb_pkg::CMD_PROBE;
		fine_n        = 1'b0;
		rstart_n      = '0;
		rlen_n        = '0;
		ptype_n       = lslb_pkg::PIX_GRB;
		count_n       = '0;
		uneven_n      = 1'b0;

		c_step  = step_q >> 1;
		c_last  = last_on_q;
		c_first = first_off_q;
		c_pos   = probe_q;
		f_low   = '0;
		sum     = '0;
		diff    = '0;
		fo      = '0;

		if (req.kind == lslb_pkg::KIND_START) begin
			// start: light bytes 0..2 on the new channel
			chan_n   = req.channel;
			phase_n  = lslb_pkg::PH_FIRST;
			has_rsp  = 1'b1;
			rlen_n   = lslb_pkg::COARSE_LEN;
		end else begin
			unique case (phase_q)
				lslb_pkg::PH_FIRST: begin
					has_rsp = 1'b1;
					if (off12) begin
						// nothing lit: empty strip
						phase_n = lslb_pkg::PH_IDLE;
						cmd_n   = lslb_pkg::CMD_FINISH;
					end else begin
						last_on_n   = 11'd3;
						first_off_n = INIT_FIRST_OFF;
						probe_n     = INIT_PROBE;
						step_n      = INIT_STEP;
						phase_n     = lslb_pkg::PH_COARSE;
						rstart_n    = INIT_PROBE;
						rlen_n      = lslb_pkg::COARSE_LEN;
					end
				end
				lslb_pkg::PH_COARSE: begin
					has_rsp = 1'b1;
					if (off12) begin
						c_first = probe_q;
						c_pos   = probe_q - step_q;
					end else begin
						c_last = probe_q + 11'd3;
						c_pos  = probe_q + step_q;
					end
					step_n      = c_step;
					first_off_n = c_first;
					if (c_step >= lslb_pkg::MIN_COARSE_STEP) begin
						last_on_n = c_last;
						probe_n   = c_pos;
						rstart_n  = c_pos;
						rlen_n    = lslb_pkg::COARSE_LEN;
					end else begin
						// switch to fine bisection
						f_low         = c_last - 11'd2;
						sum           = {1'b0, f_low} + {1'b0, c_first};
						coarse_base_n = c_first;
						last_on_n     = f_low;
						probe_n       = sum[PW:1];
						phase_n       = lslb_pkg::PH_FINE;
						rstart_n      = sum[PW:1];
						rlen_n        = lslb_pkg::FINE_LEN;
						fine_n        = 1'b1;
					end
				end
				lslb_pkg::PH_FINE: begin
					has_rsp = 1'b1;
					if (off14) begin
						c_first = probe_q;
					end else begin
						c_last = probe_q + 11'd1;
					end
					first_off_n = c_first;
					last_on_n   = c_last;
					if (c_last < c_first) begin
						sum      = {1'b0, c_last} + {1'b0, c_first};
						probe_n  = sum[PW:1];
						rstart_n = sum[PW:1];
						rlen_n   = lslb_pkg::FINE_LEN;
						fine_n   = 1'b1;
					end else begin
						// bounds met: classify the byte count
						phase_n = lslb_pkg::PH_IDLE;
						cmd_n   = lslb_pkg::CMD_FINISH;
						diff    = {5'd0, coarse_base_q} - {5'd0, c_first};
						fo      = {1'b0, c_first};
						if (diff == 16'd0 || diff == 16'd3 || diff == 16'd6 ||
						    diff == 16'd9) begin
							count_n = lslb_pkg::div3(fo);
						end else if (diff == 16'd4 || diff == 16'd8) begin
							ptype_n = lslb_pkg::PIX_RGBW;
							count_n = {1'b0, c_first[PW-1:2]};
						end else begin
							count_n  = lslb_pkg::div3(fo + 12'd2);
							uneven_n = 1'b1;
						end
					end
				end
				default: begin
					// idle: stray reply, no result
				end
			endcase
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_ref_q <= '0;
		end else if (cfg_we) begin
			off_ref_q <= cfg_wdata;
		end
	end

	// detection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= lslb_pkg::PH_IDLE;
			last_on_q     <= '0;
			first_off_q   <= '0;
			probe_q       <= '0;
			step_q        <= '0;
			coarse_base_q <= '0;
			chan_q        <= '0;
		end else if (accept) begin
			phase_q       <= phase_n;
			last_on_q     <= last_on_n;
			first_off_q   <= first_off_n;
			probe_q       <= probe_n;
			step_q        <= step_n;
			coarse_base_q <= coarse_base_n;
			chan_q        <= chan_n;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= has_rsp;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept && has_rsp) begin
			cmd_q    <= cmd_n;
			ochan_q  <= chan_n;
			rstart_q <= rstart_n;
			rend_q   <= rstart_n + {9'd0, rlen_n};
			fine_q   <= fine_n;
			ptype_q  <= ptype_n;
			count_q  <= count_n;
			uneven_q <= uneven_n;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.command        = cmd_q;
	assign rsp.out_channel    = ochan_q;
	assign rsp.range_start    = rstart_q;
	assign rsp.range_end      = rend_q;
	assign rsp.fine_precision = fine_q;
	assign rsp.pixel_format   = ptype_q;
	assign rsp.pixel_total    = count_q;
	assign rsp.uneven_count   = uneven_q;

endmodule
